[rtl/software_timer_table_defines.svh]
// assertion macros for the software timer table
`ifndef SOFTWARE_TIMER_TABLE_DEFINES_SVH
`define SOFTWARE_TIMER_TABLE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define STT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("software_timer_table: assertion failed");

// next-cycle implication
`define STT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("software_timer_table: assertion failed");

`else

`define STT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define STT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[rtl/stt_pkg.sv]
// types, codes and widths shared by the software timer table
`default_nettype none

package stt_pkg;

  localparam int NUM_TIMERS_DEF = 8;
  localparam int MAX_FIRED      = 8;
  localparam int FIRE_CNT_W     = $clog2(MAX_FIRED + 1);

  localparam int OP_W     = 2;
  localparam int PERIOD_W = 32;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TICK     = 2'd2,
    OP_SERVICE  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_ARG   = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  // one timer slot as held in the table memory
  typedef struct packed {
    logic                periodic;
    logic                pending;
    logic [PERIOD_W-1:0] reload;
    logic [PERIOD_W-1:0] count;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

endpackage

`default_nettype wire

[rtl/software_timer_table.sv]
// Software timer table. Timer slots live in a single-port-read, single-port-write
// memory; the per-slot live flags sit in flip-flops cleared at reset, so a slot
// that is not live is treated as free whatever the memory holds and no clearing
// pass is needed. Every command walks the whole table one slot per cycle
// through the memory's read port, unless a fire waits for a free output, and
// writes each modified slot back from the modify stage after its read. A new
// command is accepted only once the walk has finished and its final word is
// loaded; out_ready held low delays this. Register, delete and tick give one
// word; service gives one word per expired timer (at most eight, lowest slots
// first) or one empty word, the final one flagged by out_last. A result waits in
// the output register while the next command is accepted.
`default_nettype none

`include "software_timer_table_defines.svh"

module software_timer_table #(
  parameter int NUM_TIMERS = stt_pkg::NUM_TIMERS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [stt_pkg::OP_W-1:0]     in_op,
  input  wire                          in_is_loop,
  input  wire  [stt_pkg::PERIOD_W-1:0] in_period_ms,
  input  wire  [stt_pkg::HANDLE_W-1:0] in_handle,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [stt_pkg::STATUS_W-1:0] out_status,
  output logic                         out_fired,
  output logic [stt_pkg::SLOT_W-1:0]   out_slot,
  output logic [stt_pkg::HANDLE_W-1:0] out_fired_handle,
  output logic                         out_last
);

  import stt_pkg::*;

  localparam int IDX_W  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int SCAN_W = $clog2(NUM_TIMERS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINISH
  } state_t;

  state_t                  state_r;
  op_t                     op_r;
  logic                    loop_r;
  logic [PERIOD_W-1:0]     period_r;
  logic [HANDLE_W-1:0]     handle_r;
  logic                    bad_r;

  logic [SCAN_W-1:0]       scan_r;
  logic                    proc_valid_r;
  logic [IDX_W-1:0]        proc_idx_r;
  logic                    found_r;
  logic [SLOT_W-1:0]       slot_r;
  logic [FIRE_CNT_W-1:0]   fire_cnt_r;

  logic                    held_valid_r;
  logic [SLOT_W-1:0]       held_slot_r;
  logic [HANDLE_W-1:0]     held_handle_r;

  logic [NUM_TIMERS-1:0]   used_r;

  logic                    out_valid_r;
  logic [STATUS_W-1:0]     out_status_r;
  logic                    out_fired_r;
  logic [SLOT_W-1:0]       out_slot_r;
  logic [HANDLE_W-1:0]     out_handle_r;
  logic                    out_last_r;

  // table memory
  entry_t                  mem [NUM_TIMERS];
  entry_t                  rd_data_r;

  entry_t                  ent;
  entry_t                  mem_wdata;
  logic                    used_cur;
  logic                    mod_we;
  logic                    mod_used_set;
  logic                    mod_used_clr;
  logic                    mod_found;
  logic                    fire;
  logic                    out_free;
  logic                    stall;
  logic                    adv;
  logic                    mem_we;
  logic                    mem_re;
  logic                    scan_more;
  logic                    push_held;
  logic                    out_load;

  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_ready;
  assign scan_more = (scan_r < SCAN_W'(NUM_TIMERS));

  // modify stage: work on the slot whose read data has just arrived
  always_comb begin
    ent          = rd_data_r;
    used_cur     = used_r[proc_idx_r];
    mem_wdata    = ent;
    mod_we       = 1'b0;
    mod_used_set = 1'b0;
    mod_used_clr = 1'b0;
    mod_found    = 1'b0;
    fire         = 1'b0;
    if (state_r == S_RUN && proc_valid_r) begin
      case (op_r)
        OP_REGISTER: begin
          if (!bad_r && !found_r && !used_cur) begin
            mod_we           = 1'b1;
            mod_used_set     = 1'b1;
            mod_found        = 1'b1;
            mem_wdata.periodic = loop_r;
            mem_wdata.pending  = 1'b0;
            mem_wdata.reload   = period_r;
            mem_wdata.count    = period_r;
            mem_wdata.handle   = handle_r;
          end
        end
        OP_DELETE: begin
          // a zero handle matches exactly the free slots
          if ((handle_r == '0) ? !used_cur : (used_cur && ent.handle == handle_r)) begin
            mod_used_clr = 1'b1;
            mod_found    = 1'b1;
          end
        end
        OP_TICK: begin
          if (used_cur) begin
            mod_we = 1'b1;
            if (ent.count != '0) begin
              mem_wdata.count = ent.count - PERIOD_W'(1);
            end else begin
              mem_wdata.pending = 1'b1;
              if (ent.periodic) begin
                mem_wdata.count = ent.reload;
              end
            end
          end
        end
        OP_SERVICE: begin
          if (used_cur && ent.pending && fire_cnt_r < FIRE_CNT_W'(MAX_FIRED)) begin
            fire = 1'b1;
            if (ent.periodic) begin
              mod_we            = 1'b1;
              mem_wdata.pending = 1'b0;
            end else begin
              mod_used_clr = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // a new fire pushes the previously held one out, which needs a free output
  assign stall     = fire && held_valid_r && !out_free;
  assign adv       = !stall;
  assign mem_we    = mod_we && adv;
  assign mem_re    = (state_r == S_RUN) && adv && scan_more;
  assign push_held = fire && held_valid_r && adv;
  assign out_load  = push_held || ((state_r == S_FINISH) && out_free);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[proc_idx_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[scan_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      used_r       <= '0;
      proc_valid_r <= 1'b0;
      held_valid_r <= 1'b0;
      found_r      <= 1'b0;
      fire_cnt_r   <= '0;
      scan_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r         <= op_t'(in_op);
            loop_r       <= in_is_loop;
            period_r     <= in_period_ms;
            handle_r     <= in_handle;
            bad_r        <= (in_period_ms == '0) || (in_handle == '0);
            scan_r       <= '0;
            proc_valid_r <= 1'b0;
            found_r      <= 1'b0;
            slot_r       <= '0;
            fire_cnt_r   <= '0;
            held_valid_r <= 1'b0;
            state_r      <= S_RUN;
          end
        end
        S_RUN: begin
          if (adv) begin
            if (mod_used_set) begin
              used_r[proc_idx_r] <= 1'b1;
            end
            if (mod_used_clr) begin
              used_r[proc_idx_r] <= 1'b0;
            end
            if (mod_found) begin
              found_r <= 1'b1;
              slot_r  <= SLOT_W'(proc_idx_r);
            end
            if (fire) begin
              held_valid_r  <= 1'b1;
              held_slot_r   <= SLOT_W'(proc_idx_r);
              held_handle_r <= ent.handle;
              fire_cnt_r    <= fire_cnt_r + FIRE_CNT_W'(1);
            end
            if (push_held) begin
              out_status_r <= STATUS_OK;
              out_fired_r  <= 1'b1;
              out_slot_r   <= held_slot_r;
              out_handle_r <= held_handle_r;
              out_last_r   <= 1'b0;
            end
            if (scan_more) begin
              proc_idx_r   <= scan_r[IDX_W-1:0];
              proc_valid_r <= 1'b1;
              scan_r       <= SCAN_W'(scan_r + SCAN_W'(1));
            end else begin
              proc_valid_r <= 1'b0;
              if (!proc_valid_r) begin
                state_r <= S_FINISH;
              end
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_fired_r  <= 1'b0;
            out_slot_r   <= '0;
            out_handle_r <= '0;
            out_last_r   <= 1'b1;
            case (op_r)
              OP_REGISTER: begin
                if (bad_r) begin
                  out_status_r <= STATUS_BAD_ARG;
                end else if (found_r) begin
                  out_status_r <= STATUS_OK;
                  out_slot_r   <= slot_r;
                end else begin
                  out_status_r <= STATUS_FULL;
                end
              end
              OP_DELETE: begin
                out_status_r <= found_r ? STATUS_OK : STATUS_NOT_FOUND;
              end
              OP_SERVICE: begin
                out_status_r <= STATUS_OK;
                if (held_valid_r) begin
                  out_fired_r  <= 1'b1;
                  out_slot_r   <= held_slot_r;
                  out_handle_r <= held_handle_r;
                end
              end
              default: begin
                out_status_r <= STATUS_OK;
              end
            endcase
            held_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_fired        = out_fired_r;
  assign out_slot         = out_slot_r;
  assign out_fired_handle = out_handle_r;
  assign out_last         = out_last_r;

  // read and write back never hit the same slot in one cycle
  `STT_ASSERT_IMPL(a_no_rw_clash, clk, rst_n, mem_we && mem_re,
                   proc_idx_r != scan_r[IDX_W-1:0])
  // register only ever claims a free slot
  `STT_ASSERT_IMPL(a_reg_free_slot, clk, rst_n, mod_used_set && adv,
                   !used_r[proc_idx_r] && op_r == OP_REGISTER)
  // words without the last flag come only from a service walk
  `STT_ASSERT_IMPL(a_mid_word_service, clk, rst_n, push_held,
                   op_r == OP_SERVICE && state_r == S_RUN)
  // no more than eight expired timers are reported per service
  `STT_ASSERT_IMPL(a_fire_cap, clk, rst_n, state_r == S_RUN,
                   fire_cnt_r <= FIRE_CNT_W'(MAX_FIRED))

endmodule

`default_nettype wire

[tb/software_timer_table_test.sv]
// self-checking testbench for the software timer table: directed then random commands
`timescale 1ns / 1ps

module software_timer_table_test;
  import stt_pkg::*;

  localparam int TIMERS     = NUM_TIMERS_DEF;
  localparam int RAND_CMDS  = 85;
  localparam int CYCLE_CAP  = 200000;
  localparam int IDLE_PCT   = 17;
  localparam int DRAIN_WAIT = 64;

  typedef struct packed {
    op_t                 op;
    logic                is_loop;
    logic [PERIOD_W-1:0] period;
    logic [HANDLE_W-1:0] handle;
  } timer_cmd_t;

  typedef struct packed {
    status_t             status;
    logic                fired;
    logic [SLOT_W-1:0]   slot;
    logic [HANDLE_W-1:0] handle;
    logic                last;
  } timer_word_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     in_op = OP_TICK;
  logic                in_is_loop = 1'b0;
  logic [PERIOD_W-1:0] in_period_ms = '0;
  logic [HANDLE_W-1:0] in_handle = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic                out_fired;
  logic [SLOT_W-1:0]   out_slot;
  logic [HANDLE_W-1:0] out_fired_handle;
  logic                out_last;

  software_timer_table u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_is_loop       (in_is_loop),
    .in_period_ms     (in_period_ms),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_fired        (out_fired),
    .out_slot         (out_slot),
    .out_fired_handle (out_fired_handle),
    .out_last         (out_last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the timer table
  bit                  tm_used     [TIMERS];
  bit                  tm_periodic [TIMERS];
  bit                  tm_pending  [TIMERS];
  logic [PERIOD_W-1:0] tm_reload   [TIMERS];
  logic [PERIOD_W-1:0] tm_count    [TIMERS];
  logic [HANDLE_W-1:0] tm_handle   [TIMERS];

  timer_cmd_t  cmd_backlog[$];
  timer_word_t due_words[$];
  timer_cmd_t  cur_cmd;
  timer_cmd_t  next_cmd;
  timer_word_t got_word;
  int          cycle_cnt = 0;
  int          err_count = 0;
  bit          quiet;

  assign quiet = (cycle_cnt >= 400) && (cycle_cnt < 1000);

  function automatic timer_word_t make_word(status_t st, logic fd, int sl,
                                            logic [HANDLE_W-1:0] h, logic lst);
    timer_word_t w;
    w.status = st;
    w.fired  = fd;
    w.slot   = sl[SLOT_W-1:0];
    w.handle = h;
    w.last   = lst;
    return w;
  endfunction

  function automatic void wipe_timer(int i);
    tm_used[i]     = 1'b0;
    tm_periodic[i] = 1'b0;
    tm_pending[i]  = 1'b0;
    tm_reload[i]   = '0;
    tm_count[i]    = '0;
    tm_handle[i]   = '0;
  endfunction

  // updates the shadow table and queues the words this command should produce
  function automatic void apply_timer_cmd(timer_cmd_t c);
    bit hit;
    int n;
    hit = 1'b0;
    n   = 0;
    case (c.op)
      OP_REGISTER: begin
        if (c.period == '0 || c.handle == '0) begin
          due_words.push_back(make_word(STATUS_BAD_ARG, 1'b0, 0, '0, 1'b1));
        end else begin
          for (int i = 0; i < TIMERS; i++) begin
            if (!hit && !tm_used[i]) begin
              hit            = 1'b1;
              tm_used[i]     = 1'b1;
              tm_periodic[i] = c.is_loop;
              tm_pending[i]  = 1'b0;
              tm_reload[i]   = c.period;
              tm_count[i]    = c.period;
              tm_handle[i]   = c.handle;
              due_words.push_back(make_word(STATUS_OK, 1'b0, i, '0, 1'b1));
            end
          end
          if (!hit) due_words.push_back(make_word(STATUS_FULL, 1'b0, 0, '0, 1'b1));
        end
      end
      OP_DELETE: begin
        // free slots hold a zero handle, so a zero handle matches them
        for (int i = 0; i < TIMERS; i++) begin
          if (tm_handle[i] == c.handle) begin
            wipe_timer(i);
            hit = 1'b1;
          end
        end
        due_words.push_back(make_word(hit ? STATUS_OK : STATUS_NOT_FOUND,
                                      1'b0, 0, '0, 1'b1));
      end
      OP_TICK: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (tm_used[i]) begin
            if (tm_count[i] != '0) begin
              tm_count[i] = tm_count[i] - PERIOD_W'(1);
            end else begin
              tm_pending[i] = 1'b1;
              if (tm_periodic[i]) tm_count[i] = tm_reload[i];
            end
          end
        end
        due_words.push_back(make_word(STATUS_OK, 1'b0, 0, '0, 1'b1));
      end
      default: begin
        for (int i = 0; i < TIMERS; i++) begin
          if (n < MAX_FIRED && tm_used[i] && tm_pending[i]) begin
            due_words.push_back(make_word(STATUS_OK, 1'b1, i, tm_handle[i], 1'b0));
            n++;
            tm_pending[i] = 1'b0;
            if (!tm_periodic[i]) wipe_timer(i);
          end
        end
        if (n == 0) due_words.push_back(make_word(STATUS_OK, 1'b0, 0, '0, 1'b1));
        else due_words[$].last = 1'b1;
      end
    endcase
  endfunction

  function automatic timer_cmd_t make_cmd(op_t op, logic lp, logic [PERIOD_W-1:0] p,
                                          logic [HANDLE_W-1:0] h);
    timer_cmd_t c;
    c.op      = op;
    c.is_loop = lp;
    c.period  = p;
    c.handle  = h;
    return c;
  endfunction

  // small pool so that deletes hit and duplicates occur, with the odd outlier
  function automatic logic [HANDLE_W-1:0] pick_handle();
    int r;
    r = $urandom_range(99);
    if (r < 4) return '0;
    if (r < 12) return HANDLE_W'($urandom);
    return HANDLE_W'($urandom_range(10, 1));
  endfunction

  initial begin
    int r;
    logic [PERIOD_W-1:0] p;
    for (int i = 0; i < TIMERS; i++) wipe_timer(i);

    cmd_backlog.push_back(make_cmd(OP_SERVICE,  1'b0, '0, '0));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b0, '0, 16'h0005));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b1, 32'd3, '0));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b1, 32'd1, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b0, 32'hFFFF_FFFF, 16'h0001));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b0, 32'd1, 16'h00AA));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b1, 32'd2, 16'h00AA));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b1, 32'h8000_0000, 16'h5555));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b0, 32'h5555_5555, 16'hAAAA));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b1, 32'hAAAA_AAAA, 16'h8000));
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b0, 32'd4, 16'h0003));
    // table full from here
    cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'b1, 32'd2, 16'h0007));
    cmd_backlog.push_back(make_cmd(OP_DELETE,   1'b0, '0, '0));
    for (int i = 0; i < 3; i++)
      cmd_backlog.push_back(make_cmd(OP_TICK, 1'b1, 32'hFFFF_FFFF, 16'hFFFF));
    cmd_backlog.push_back(make_cmd(OP_SERVICE,  1'b1, '1, '1));
    cmd_backlog.push_back(make_cmd(OP_DELETE,   1'b0, '0, 16'h00AA));
    cmd_backlog.push_back(make_cmd(OP_DELETE,   1'b0, '0, 16'h1234));
    cmd_backlog.push_back(make_cmd(OP_DELETE,   1'b1, '1, '0));
    cmd_backlog.push_back(make_cmd(OP_SERVICE,  1'b0, '0, '0));
    for (int i = 0; i < 3; i++)
      cmd_backlog.push_back(make_cmd(OP_TICK, 1'b0, '0, '0));
    cmd_backlog.push_back(make_cmd(OP_SERVICE,  1'b0, '0, '0));

    for (int k = 0; k < RAND_CMDS; k++) begin
      r = $urandom_range(99);
      if (r < 32) begin
        r = $urandom_range(99);
        if (r < 5) p = '0;
        else if (r < 13) p = $urandom;
        else p = PERIOD_W'($urandom_range(5, 1));
        cmd_backlog.push_back(make_cmd(OP_REGISTER, 1'($urandom), p, pick_handle()));
      end else if (r < 45) begin
        cmd_backlog.push_back(make_cmd(OP_DELETE, 1'($urandom), $urandom, pick_handle()));
      end else if (r < 78) begin
        cmd_backlog.push_back(make_cmd(OP_TICK, 1'($urandom), $urandom, 16'($urandom)));
      end else begin
        cmd_backlog.push_back(make_cmd(OP_SERVICE, 1'($urandom), $urandom, 16'($urandom)));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_valid) @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_cnt, due_words.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // command driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) apply_timer_cmd(cur_cmd);
      if (!in_valid || in_ready) begin
        if (cmd_backlog.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
          next_cmd = cmd_backlog.pop_front();
          cur_cmd      <= next_cmd;
          in_op        <= next_cmd.op;
          in_is_loop   <= next_cmd.is_loop;
          in_period_ms <= next_cmd.period;
          in_handle    <= next_cmd.handle;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        got_word.status = status_t'(out_status);
        got_word.fired  = out_fired;
        got_word.slot   = out_slot;
        got_word.handle = out_fired_handle;
        got_word.last   = out_last;
        if (due_words.size() == 0) begin
          err_count <= err_count + 1;
          if (err_count < 10)
            $display("unexpected word: status=%0d fired=%0d slot=%0d handle=%h last=%0d",
                     got_word.status, got_word.fired, got_word.slot, got_word.handle,
                     got_word.last);
        end else begin
          if (got_word !== due_words[0]) begin
            err_count <= err_count + 1;
            if (err_count < 10)
              $display({"mismatch: expected status=%0d fired=%0d slot=%0d handle=%h last=%0d",
                        " got status=%0d fired=%0d slot=%0d handle=%h last=%0d"},
                       due_words[0].status, due_words[0].fired, due_words[0].slot,
                       due_words[0].handle, due_words[0].last,
                       got_word.status, got_word.fired, got_word.slot, got_word.handle,
                       got_word.last);
          end
          void'(due_words.pop_front());
        end
      end
    end
  end

endmodule

[files.f]
+incdir+rtl
rtl/stt_pkg.sv
rtl/software_timer_table.sv
tb/software_timer_table_test.sv
